// File: sv/co2f_pkg.sv
// Shared types and constants for the CO2 threshold averaging fan controller.
`timescale 1ns / 1ps
`default_nettype none

package co2f_pkg;

	// Field and state widths.
	localparam int SampleW = 16;
	localparam int SumW    = 26;
	localparam int CountW  = 10;
	localparam int DelayW  = 16;
	localparam int IndexW  = 2;

	// Most samples that one judging period sums.
	localparam int MaxSamples = 600;

	// Divider step counter width.
	localparam int StepW = $clog2(SumW);

	// Register reset values.
	localparam logic [SampleW-1:0] ThresholdReset = SampleW'(800);
	localparam logic [DelayW-1:0]  OnDelayReset   = DelayW'(180);
	localparam logic [DelayW-1:0]  OffDelayReset  = DelayW'(120);

	// Configuration register indexes.
	localparam logic [IndexW-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IndexW-1:0] REG_ON_DELAY  = 2'd1;
	localparam logic [IndexW-1:0] REG_OFF_DELAY = 2'd2;

	// Item kinds.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Controller mode, encoded as reported on mode_now.
	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_ACTIVE  = 2'd1,
		MODE_JUDGING = 2'd2
	} mode_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		SEQ_READY,
		SEQ_DIVIDE,
		SEQ_RESULT
	} seq_t;

endpackage

`default_nettype wire

// File: sv/co2f_div.sv
// Restoring serial divider: one quotient bit per cycle for the sample average.
`timescale 1ns / 1ps
`default_nettype none

module co2f_div
	import co2f_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SumW-1:0]   dividend,
	input  wire logic [CountW-1:0] divisor,
	output logic                   done,
	output logic [SumW-1:0]        quotient
);

	logic [CountW-1:0] rem_q;
	logic [SumW-1:0]   quo_q;
	logic [CountW-1:0] div_q;
	logic [StepW-1:0]  step_q;
	logic              busy_q;
	logic              done_q;

	logic [CountW:0] shifted;
	logic [CountW:0] diff;
	logic            fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[SumW-1]};
		diff    = shifted - {1'b0, div_q};
		fits    = shifted >= {1'b0, div_q};
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == StepW'(SumW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CountW-1:0] : shifted[CountW-1:0];
			quo_q <= {quo_q[SumW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: sv/co2_threshold_averaging_fan_control.sv
// Top level of the CO2 threshold averaging fan controller with its sequencer.
//
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    operation, co2_sample
// result   out        out_valid / out_stall  fan_on, mode_now, decided, average_level
// config   in         cfg_we                 cfg_index, cfg_data
//
// A sample, a tick that does not end judging, and a decision over zero samples
// show their result in the cycle after acceptance. A tick that ends judging over
// collected samples runs the serial divider, one quotient bit per cycle for 26
// bits, and shows its result when the divider reports done. The block takes one item
// at a time: in_stall stays high from acceptance until the result is taken, and a
// stalled result holds. Reset brings idle mode, fan off and default registers.
`timescale 1ns / 1ps
`default_nettype none

module co2_threshold_averaging_fan_control
	import co2f_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               operation,
	input  wire logic [SampleW-1:0] co2_sample,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    fan_on,
	output logic [1:0]              mode_now,
	output logic                    decided,
	output logic [SampleW-1:0]      average_level,
	input  wire logic               cfg_we,
	input  wire logic [IndexW-1:0]  cfg_index,
	input  wire logic [SampleW-1:0] cfg_data
);

	seq_t              seq_q, seq_d;
	mode_t             mode_q, mode_d;
	logic [DelayW-1:0] delay_q, delay_d;
	logic [SumW-1:0]   sum_q, sum_d;
	logic [CountW-1:0] count_q, count_d;
	logic              fan_q, fan_d;
	logic              decided_q, decided_d;
	logic [SampleW-1:0] avg_q, avg_d;

	logic [SampleW-1:0] threshold_q;
	logic [DelayW-1:0]  on_delay_q;
	logic [DelayW-1:0]  off_delay_q;

	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [SumW-1:0]   div_quo;
	logic [SampleW-1:0] div_avg;
	mode_t             eff_mode;

	assign accept = in_valid && !in_stall;

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ThresholdReset;
			on_delay_q  <= OnDelayReset;
			off_delay_q <= OffDelayReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_ON_DELAY:  on_delay_q  <= cfg_data;
				REG_OFF_DELAY: off_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Serial divider for the judging average.
	co2f_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Saturate the quotient to the sample width.
	assign div_avg = (|div_quo[SumW-1:SampleW]) ? '1 : div_quo[SampleW-1:0];

	// Sequencer next state and controller state updates.
	always_comb begin
		seq_d     = seq_q;
		mode_d    = mode_q;
		delay_d   = delay_q;
		sum_d     = sum_q;
		count_d   = count_q;
		fan_d     = fan_q;
		decided_d = decided_q;
		avg_d     = avg_q;
		div_start = 1'b0;
		eff_mode  = mode_q;

		unique case (seq_q)
			SEQ_READY: begin
				if (accept) begin
					seq_d     = SEQ_RESULT;
					decided_d = 1'b0;
					avg_d     = '0;
					if (operation == OP_SAMPLE) begin
						// A crossing sample opens a judging period.
						if (mode_q == MODE_IDLE && co2_sample > threshold_q) begin
							eff_mode = MODE_JUDGING;
							delay_d  = on_delay_q;
						end else if (mode_q == MODE_ACTIVE && co2_sample < threshold_q) begin
							eff_mode = MODE_JUDGING;
							delay_d  = off_delay_q;
						end
						mode_d = eff_mode;
						if (eff_mode == MODE_JUDGING && count_q < CountW'(MaxSamples)) begin
							sum_d   = sum_q + SumW'(co2_sample);
							count_d = count_q + 1'b1;
						end
					end else if (mode_q == MODE_JUDGING) begin
						if (delay_q <= DelayW'(1)) begin
							decided_d = 1'b1;
							if (count_q == '0) begin
								// An empty period averages to zero, which turns the fan off.
								mode_d  = MODE_IDLE;
								fan_d   = 1'b0;
								sum_d   = '0;
								count_d = '0;
								delay_d = '0;
							end else begin
								div_start = 1'b1;
								seq_d     = SEQ_DIVIDE;
							end
						end else begin
							delay_d = delay_q - 1'b1;
						end
					end
				end
			end
			SEQ_DIVIDE: begin
				if (div_done) begin
					avg_d = div_avg;
					if (div_avg > threshold_q) begin
						mode_d = MODE_ACTIVE;
						fan_d  = 1'b1;
					end else begin
						mode_d = MODE_IDLE;
						fan_d  = 1'b0;
					end
					sum_d   = '0;
					count_d = '0;
					delay_d = '0;
					seq_d   = SEQ_RESULT;
				end
			end
			SEQ_RESULT: begin
				if (!out_stall) begin
					seq_d = SEQ_READY;
				end
			end
			default: seq_d = SEQ_READY;
		endcase
	end

	// Sequencer and controller state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= SEQ_READY;
			mode_q  <= MODE_IDLE;
			delay_q <= '0;
			sum_q   <= '0;
			count_q <= '0;
			fan_q   <= 1'b0;
		end else begin
			seq_q   <= seq_d;
			mode_q  <= mode_d;
			delay_q <= delay_d;
			sum_q   <= sum_d;
			count_q <= count_d;
			fan_q   <= fan_d;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		decided_q <= decided_d;
		avg_q     <= avg_d;
	end

	assign in_stall      = (seq_q != SEQ_READY);
	assign out_valid     = (seq_q == SEQ_RESULT);
	assign fan_on        = fan_q;
	assign mode_now      = mode_q;
	assign decided       = decided_q;
	assign average_level = avg_q;

	// A pending result keeps the input side closed.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("input accepted while a result is pending");

	// A decision always leaves judging.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && decided) |-> (mode_now != MODE_JUDGING))
		else $error("decision left the controller judging");

	// Outside judging the fan follows the mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_ACTIVE) |-> fan_q)
		else $error("active mode with fan off");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> !fan_q)
		else $error("idle mode with fan on");

	// The sample count never passes the cap.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(MaxSamples))
		else $error("sample count above cap");

endmodule

`default_nettype wire

// File: sim/co2_threshold_averaging_fan_control_test.sv
// Self-checking testbench for the CO2 threshold averaging fan controller.
`timescale 1ns / 1ps

module co2_threshold_averaging_fan_control_test;
	import co2f_pkg::*;

	// Index past the end of the register list; writes to it must be dropped.
	localparam logic [IndexW-1:0] REG_UNUSED = 2'd3;

	// One result transaction as the block reports it.
	typedef struct packed {
		logic               fan;
		mode_t              mode;
		logic               done;
		logic [SampleW-1:0] avg;
	} fan_report_t;

	// One row of the directed plan: either a register write or an item.
	typedef struct packed {
		logic               is_write;
		logic [IndexW-1:0]  idx;
		logic               op;
		logic [SampleW-1:0] value;
		logic               typed;
		fan_report_t        want;
	} step_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = OP_SAMPLE;
	logic [SampleW-1:0] co2_sample = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               fan_on;
	logic [1:0]         mode_now;
	logic               decided;
	logic [SampleW-1:0] average_level;
	logic               cfg_we = 1'b0;
	logic [IndexW-1:0]  cfg_index = REG_THRESHOLD;
	logic [SampleW-1:0] cfg_data = '0;

	// Idle rates in percent for the sending and receiving sides.
	int gap_pct = 13;
	int hold_pct = 51;
	int faults = 0;

	// Expected results in order of acceptance.
	fan_report_t pending_reports[$];

	// Predicted controller state and register copies.
	mode_t              ctl_mode = MODE_IDLE;
	logic [DelayW-1:0]  ticks_left = '0;
	logic [SumW-1:0]    level_sum = '0;
	logic [CountW-1:0]  level_count = '0;
	logic               fan_state = 1'b0;
	logic [SampleW-1:0] thr_ppm = ThresholdReset;
	logic [DelayW-1:0]  on_ticks = OnDelayReset;
	logic [DelayW-1:0]  off_ticks = OffDelayReset;

	co2_threshold_averaging_fan_control dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.co2_sample(co2_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fan_on(fan_on),
		.mode_now(mode_now),
		.decided(decided),
		.average_level(average_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Advances the predicted controller by one item and returns its report.
	function automatic fan_report_t advance_controller(input logic op,
			input logic [SampleW-1:0] level);
		fan_report_t r;
		logic [SumW-1:0] mean;
		r = '0;
		mean = '0;
		if (op == OP_SAMPLE) begin
			// Crossing the threshold opens a judging period.
			if (ctl_mode == MODE_IDLE && level > thr_ppm) begin
				ctl_mode = MODE_JUDGING;
				ticks_left = on_ticks;
			end else if (ctl_mode == MODE_ACTIVE && level < thr_ppm) begin
				ctl_mode = MODE_JUDGING;
				ticks_left = off_ticks;
			end
			if (ctl_mode == MODE_JUDGING && level_count < MaxSamples) begin
				level_sum = level_sum + level;
				level_count = level_count + 1'b1;
			end
		end else if (ctl_mode == MODE_JUDGING) begin
			if (ticks_left <= 1) begin
				// Judging ends: the average decides the fan.
				if (level_count != 0)
					mean = level_sum / level_count;
				if (mean > 'hFFFF)
					mean = 'hFFFF;
				if (mean > thr_ppm) begin
					ctl_mode = MODE_ACTIVE;
					fan_state = 1'b1;
				end else begin
					ctl_mode = MODE_IDLE;
					fan_state = 1'b0;
				end
				level_sum = '0;
				level_count = '0;
				ticks_left = '0;
				r.done = 1'b1;
				r.avg = mean[SampleW-1:0];
			end else begin
				ticks_left = ticks_left - 1'b1;
			end
		end
		r.fan = fan_state;
		r.mode = ctl_mode;
		return r;
	endfunction

	// Sample level mostly near the threshold, sometimes anywhere or at an extreme.
	function automatic logic [SampleW-1:0] pick_level();
		int pick;
		int lvl;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return SampleW'($urandom);
		if (pick == 1)
			return $urandom_range(0, 1) ? '1 : '0;
		lvl = int'(thr_ppm) + $urandom_range(0, 400) - 200;
		if (lvl < 0)
			lvl = 0;
		if (lvl > 65535)
			lvl = 65535;
		return SampleW'(lvl);
	endfunction

	function automatic step_t row_write(input logic [IndexW-1:0] idx,
			input logic [SampleW-1:0] val);
		step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.idx = idx;
		s.value = val;
		return s;
	endfunction

	function automatic step_t row_item(input logic op, input logic [SampleW-1:0] val);
		step_t s;
		s = '0;
		s.op = op;
		s.value = val;
		return s;
	endfunction

	function automatic step_t row_typed(input logic op, input logic [SampleW-1:0] val,
			input logic fan, input mode_t mode, input logic done,
			input logic [SampleW-1:0] avg);
		step_t s;
		s = row_item(op, val);
		s.typed = 1'b1;
		s.want.fan = fan;
		s.want.mode = mode;
		s.want.done = done;
		s.want.avg = avg;
		return s;
	endfunction

	task automatic log_fault(input string what);
		faults++;
		if (faults <= 10)
			$display("%s", what);
	endtask

	// Offers one item, waits until it is accepted and records what it should yield.
	task automatic send_item(input logic op, input logic [SampleW-1:0] val,
			input logic typed, input fan_report_t want);
		fan_report_t predicted;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		co2_sample <= val;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predicted = advance_controller(op, val);
		pending_reports.push_back(typed ? want : predicted);
	endtask

	// Stops sending and waits until every expected result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IndexW-1:0] idx, input logic [SampleW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_ppm = val;
			REG_ON_DELAY:  on_ticks = val;
			REG_OFF_DELAY: off_ticks = val;
			default: ;
		endcase
	endtask

	// Random receiver back-pressure.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < hold_pct);
	end

	// Compares each result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		fan_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				log_fault($sformatf("unexpected result: fan %0b mode %0d decided %0b avg %0d",
					fan_on, mode_now, decided, average_level));
			end else begin
				want = pending_reports.pop_front();
				if (fan_on !== want.fan || mode_now !== want.mode
						|| decided !== want.done || average_level !== want.avg)
					log_fault($sformatf({"mismatch (expected/actual): fan %0b/%0b",
						" mode %0d/%0d decided %0b/%0b avg %0d/%0d"},
						want.fan, fan_on, want.mode, mode_now,
						want.done, decided, want.avg, average_level));
			end
		end
	end

	initial begin : run
		step_t plan[$];
		fan_report_t none;
		logic op;
		int phase;
		int seg;
		none = '0;

		// Directed plan: ignored ticks, equal samples, extremes and register effects.
		plan.push_back(row_typed(OP_TICK, 16'd0, 1'b0, MODE_IDLE, 1'b0, 16'd0));
		plan.push_back(row_typed(OP_SAMPLE, 16'd800, 1'b0, MODE_IDLE, 1'b0, 16'd0));
		plan.push_back(row_typed(OP_SAMPLE, 16'd0, 1'b0, MODE_IDLE, 1'b0, 16'd0));
		plan.push_back(row_write(REG_ON_DELAY, 16'd2));
		plan.push_back(row_typed(OP_SAMPLE, 16'hFFFF, 1'b0, MODE_JUDGING, 1'b0, 16'd0));
		plan.push_back(row_item(OP_SAMPLE, 16'd801));
		plan.push_back(row_typed(OP_TICK, 16'hFFFF, 1'b0, MODE_JUDGING, 1'b0, 16'd0));
		plan.push_back(row_item(OP_TICK, 16'd0));
		plan.push_back(row_typed(OP_TICK, 16'd0, 1'b1, MODE_ACTIVE, 1'b0, 16'd0));
		plan.push_back(row_typed(OP_SAMPLE, 16'd800, 1'b1, MODE_ACTIVE, 1'b0, 16'd0));
		// A zero delay ends judging on the first tick.
		plan.push_back(row_write(REG_OFF_DELAY, 16'd0));
		plan.push_back(row_typed(OP_SAMPLE, 16'd0, 1'b1, MODE_JUDGING, 1'b0, 16'd0));
		plan.push_back(row_typed(OP_TICK, 16'd0, 1'b0, MODE_IDLE, 1'b1, 16'd0));
		plan.push_back(row_write(REG_THRESHOLD, 16'd0));
		plan.push_back(row_typed(OP_SAMPLE, 16'd1, 1'b0, MODE_JUDGING, 1'b0, 16'd0));
		// Register changes while judging leave the running delay alone.
		plan.push_back(row_write(REG_ON_DELAY, 16'hFFFF));
		plan.push_back(row_write(REG_THRESHOLD, 16'd1));
		plan.push_back(row_typed(OP_TICK, 16'd0, 1'b0, MODE_JUDGING, 1'b0, 16'd0));
		plan.push_back(row_typed(OP_TICK, 16'd0, 1'b0, MODE_IDLE, 1'b1, 16'd1));
		plan.push_back(row_write(REG_THRESHOLD, 16'hFFFE));
		plan.push_back(row_write(REG_ON_DELAY, 16'd1));
		plan.push_back(row_typed(OP_SAMPLE, 16'hFFFF, 1'b0, MODE_JUDGING, 1'b0, 16'd0));
		plan.push_back(row_typed(OP_TICK, 16'd0, 1'b1, MODE_ACTIVE, 1'b1, 16'hFFFF));
		plan.push_back(row_write(REG_THRESHOLD, 16'hFFFF));
		plan.push_back(row_typed(OP_SAMPLE, 16'hFFFF, 1'b1, MODE_ACTIVE, 1'b0, 16'd0));
		// A write past the register list must not touch the off-delay.
		plan.push_back(row_write(REG_UNUSED, 16'd5));
		plan.push_back(row_typed(OP_SAMPLE, 16'hFFFE, 1'b1, MODE_JUDGING, 1'b0, 16'd0));
		plan.push_back(row_typed(OP_TICK, 16'd0, 1'b0, MODE_IDLE, 1'b1, 16'hFFFE));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				settle();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_item(plan[i].op, plan[i].value, plan[i].typed, plan[i].want);
			end
		end

		// Random part in three idling regimes.
		for (phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 13 : (phase == 1) ? 51 : 0;
			hold_pct = (phase == 0) ? 51 : (phase == 1) ? 13 : 0;

			if (phase == 2) begin
				// One long judging period that runs past the sample cap.
				settle();
				write_reg(REG_THRESHOLD, 16'd1000);
				write_reg(REG_ON_DELAY, 16'd1);
				write_reg(REG_OFF_DELAY, 16'd1);
				while (ctl_mode == MODE_JUDGING)
					send_item(OP_TICK, '0, 1'b0, none);
				send_item(OP_SAMPLE, (ctl_mode == MODE_ACTIVE) ? 16'd0 : 16'd2000, 1'b0, none);
				repeat (MaxSamples - 1)
					send_item(OP_SAMPLE, SampleW'($urandom_range(0, 3000)), 1'b0, none);
				repeat (3)
					send_item(OP_SAMPLE, '1, 1'b0, none);
				send_item(OP_TICK, '0, 1'b0, none);
			end

			for (seg = 0; seg < 2; seg++) begin
				settle();
				write_reg(REG_THRESHOLD, ($urandom_range(0, 3) == 0) ?
					SampleW'($urandom) : SampleW'($urandom_range(500, 1500)));
				write_reg(REG_ON_DELAY, DelayW'($urandom_range(0, 6)));
				write_reg(REG_OFF_DELAY, DelayW'($urandom_range(0, 6)));
				repeat (12) begin
					op = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_SAMPLE;
					send_item(op, (op == OP_TICK) ? SampleW'($urandom) : pick_level(),
						1'b0, none);
				end
			end
		end

		// Drain, then allow time for any stray result transaction.
		settle();
		repeat (40) @(posedge clk);
		if (faults == 0 && pending_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
sv/co2f_pkg.sv
sv/co2f_div.sv
sv/co2_threshold_averaging_fan_control.sv
sim/co2_threshold_averaging_fan_control_test.sv
